FILE: hdl/rpd_pkg.sv
package rpd_pkg;

  localparam int DUTY_W  = 7;
  localparam int FRAME_W = 7;
  localparam int HOLD_W  = 8;
  localparam int IDX_W   = 2;
  localparam int DATA_W  = 8;

  localparam logic [DUTY_W-1:0]  MAX_DUTY_RESET     = 7'd30;
  localparam logic [FRAME_W-1:0] FRAME_LENGTH_RESET = 7'd100;
  localparam logic [HOLD_W-1:0]  HOLDOFF_RESET      = 8'd100;
  localparam logic [DUTY_W-1:0]  DUTY_RESET         = 7'd15;
  localparam logic [FRAME_W-1:0] FRAME_START        = 7'd1;
  localparam logic [HOLD_W-1:0]  TICKS_SAT          = 8'hFF;

  typedef enum logic [IDX_W-1:0] {
    CFG_MAX_DUTY        = 2'd0,
    CFG_FRAME_LENGTH    = 2'd1,
    CFG_RELEASE_HOLDOFF = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [DUTY_W-1:0]  max_duty;
    logic [FRAME_W-1:0] frame_length;
    logic [HOLD_W-1:0]  release_holdoff;
  } cfg_t;

  typedef struct packed {
    logic       red_on;
    logic       blue_on;
    logic       green_on;
    logic       level_indicator;
    logic [1:0] active_channel;
  } res_t;

endpackage

FILE: hdl/rpd_cfg.sv
module rpd_cfg
  import rpd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [DATA_W-1:0] cfg_data,
  output cfg_t              cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg      = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      // index three is outside the register list and is dropped
      unique case (cfg_index)
        CFG_MAX_DUTY:        cfg_nxt.max_duty        = cfg_data[DUTY_W-1:0];
        CFG_FRAME_LENGTH:    cfg_nxt.frame_length    = cfg_data[FRAME_W-1:0];
        CFG_RELEASE_HOLDOFF: cfg_nxt.release_holdoff = cfg_data[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_duty        <= MAX_DUTY_RESET;
      cfg_r.frame_length    <= FRAME_LENGTH_RESET;
      cfg_r.release_holdoff <= HOLDOFF_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

FILE: hdl/rpd_core.sv
module rpd_core
  import rpd_pkg::*;
#(
  parameter int NUM_CHANNELS = 3
) (
  input  logic clk,
  input  logic rst_n,
  input  logic step,
  input  logic up_pressed,
  input  logic down_pressed,
  input  cfg_t cfg,
  output res_t res
);

  localparam int SEL_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam logic [SEL_W-1:0] LAST_SEL = SEL_W'(NUM_CHANNELS - 1);

  logic [FRAME_W-1:0]    frame_count_r, frame_count_nxt;
  logic [SEL_W-1:0]      sel_r, sel_nxt;
  logic [DUTY_W-1:0]     duty_r, duty_nxt;
  logic [DUTY_W-1:0]     chan_duty_r   [NUM_CHANNELS];
  logic [DUTY_W-1:0]     chan_duty_nxt [NUM_CHANNELS];
  logic                  up_block_r, up_block_nxt;
  logic                  down_block_r, down_block_nxt;
  logic [HOLD_W-1:0]     ticks_r, ticks_nxt;
  logic [NUM_CHANNELS-1:0] chan_lat_r, chan_lat_nxt;
  logic                  ind_lat_r, ind_lat_nxt;
  logic [DUTY_W:0]       duty_inc;
  logic [NUM_CHANNELS+2:0] lat_pad;
  logic                  frame_start;

  always_comb begin
    duty_nxt       = duty_r;
    sel_nxt        = sel_r;
    up_block_nxt   = up_block_r;
    down_block_nxt = down_block_r;
    ticks_nxt      = ticks_r;
    duty_inc       = {1'b0, duty_r} + 1'b1;

    // up button: step with wrap, then hold off until released long enough
    if (up_pressed && !up_block_r) begin
      ticks_nxt    = '0;
      duty_nxt     = (duty_inc > {1'b0, cfg.max_duty}) ? '0 : duty_inc[DUTY_W-1:0];
      up_block_nxt = 1'b1;
    end else if (!up_pressed) begin
      if (ticks_r > cfg.release_holdoff) begin
        up_block_nxt = 1'b0;
      end else if (ticks_r != TICKS_SAT) begin
        ticks_nxt = ticks_r + 1'b1;
      end
    end

    // down button: rotate channel and load its duty, dropping any up step
    if (down_pressed && !down_block_r) begin
      sel_nxt        = (sel_r == LAST_SEL) ? '0 : sel_r + 1'b1;
      duty_nxt       = chan_duty_r[sel_nxt];
      down_block_nxt = 1'b1;
    end else if (!down_pressed) begin
      down_block_nxt = 1'b0;
    end

    for (int k = 0; k < NUM_CHANNELS; k++) begin
      chan_duty_nxt[k] = (sel_nxt == SEL_W'(k)) ? duty_nxt : chan_duty_r[k];
    end

    frame_start = (frame_count_r == FRAME_START);
    for (int k = 0; k < NUM_CHANNELS; k++) begin
      chan_lat_nxt[k] = (frame_start || chan_lat_r[k]) &&
                        !({1'b0, frame_count_r} > {1'b0, chan_duty_nxt[k]});
    end
    ind_lat_nxt = (frame_start || ind_lat_r) &&
                  !({1'b0, frame_count_r} > {1'b0, duty_nxt});

    frame_count_nxt = (frame_count_r >= cfg.frame_length) ? FRAME_START
                                                          : frame_count_r + 1'b1;
  end

  // channels that are not built read as off
  assign lat_pad = {3'b000, chan_lat_nxt};

  always_comb begin
    res.red_on          = lat_pad[0];
    res.blue_on         = lat_pad[1];
    res.green_on        = lat_pad[2];
    res.level_indicator = ind_lat_nxt;
    res.active_channel  = 2'(sel_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_count_r <= FRAME_START;
      sel_r         <= '0;
      duty_r        <= DUTY_RESET;
      up_block_r    <= 1'b0;
      down_block_r  <= 1'b0;
      ticks_r       <= '0;
      chan_lat_r    <= '0;
      ind_lat_r     <= 1'b0;
      for (int k = 0; k < NUM_CHANNELS; k++) begin
        chan_duty_r[k] <= DUTY_RESET;
      end
    end else if (step) begin
      frame_count_r <= frame_count_nxt;
      sel_r         <= sel_nxt;
      duty_r        <= duty_nxt;
      up_block_r    <= up_block_nxt;
      down_block_r  <= down_block_nxt;
      ticks_r       <= ticks_nxt;
      chan_lat_r    <= chan_lat_nxt;
      ind_lat_r     <= ind_lat_nxt;
      for (int k = 0; k < NUM_CHANNELS; k++) begin
        chan_duty_r[k] <= chan_duty_nxt[k];
      end
    end
  end

endmodule

FILE: hdl/rgb_pwm_dimmer_with_buttons.sv
// Two-button RGB PWM dimmer. Every accepted request is one tick carrying the button
// levels and yields exactly one result, the LED drives and active channel after that
// tick, captured in an output register. A request can be accepted every
// clock; the only limit is the single output register, so in_stall is high exactly
// while a result sits there and out_stall is high. Configuration registers are
// always ready and take effect on the next tick.
module rgb_pwm_dimmer_with_buttons
  import rpd_pkg::*;
#(
  parameter int NUM_CHANNELS = 3
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_up_pressed,
  input  logic              in_down_pressed,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_red_on,
  output logic              out_blue_on,
  output logic              out_green_on,
  output logic              out_level_indicator,
  output logic [1:0]        out_active_channel,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [DATA_W-1:0] cfg_data
);

  cfg_t cfg;
  res_t res;
  res_t res_r;
  logic out_valid_r, out_valid_nxt;
  logic step;

  rpd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rpd_core #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .up_pressed   (in_up_pressed),
    .down_pressed (in_down_pressed),
    .cfg          (cfg),
    .res          (res)
  );

  assign in_stall = out_valid_r && out_stall;
  assign step     = in_valid && !in_stall;

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (step) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_red_on          = res_r.red_on;
  assign out_blue_on         = res_r.blue_on;
  assign out_green_on        = res_r.green_on;
  assign out_level_indicator = res_r.level_indicator;
  assign out_active_channel  = res_r.active_channel;

endmodule
